>>> rtl/rwc_pkg.sv
`default_nettype none

package rwc_pkg;

    localparam int POS_W   = 24;
    localparam int RD_W    = 18;
    localparam int CELL_W  = 8;
    localparam int HGT_W   = 12;
    localparam int TW_W    = 11;
    localparam int WD_W    = 24;
    localparam int SLICE_W = 16;
    localparam int ROW_W   = 12;
    localparam int TEX_W   = 10;
    localparam int FL_W    = 25;
    localparam int PROD_W  = WD_W + 1 + RD_W;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [HGT_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [TW_W-1:0]  TEXTURE_WIDTH_RST = 11'd64;

    typedef enum logic
    {
        REG_SCREEN_HEIGHT = 1'b0,
        REG_TEXTURE_WIDTH = 1'b1
    } reg_idx_t;

    // Geometry that rides along with a word through both dividers.
    typedef struct packed
    {
        logic                    side;
        logic                    rdx_neg;
        logic                    rdy_neg;
        logic [CELL_W-1:0]       cx;
        logic [CELL_W-1:0]       cy;
        logic [POS_W-1:0]        other_pos;
        logic signed [RD_W-1:0]  other_rd;
    } geo_t;

    typedef struct packed
    {
        logic rd_zero;
        logic num_zero;
        logic wrong_sign;
        logic ovf;
    } dist_flags_t;

    typedef struct packed
    {
        dist_flags_t flags;
        geo_t        geo;
    } pay1_t;

    typedef struct packed
    {
        logic [WD_W-1:0]          wall_dist;
        logic                     fault;
        logic                     ovf;
        logic signed [PROD_W-1:0] prod;
        geo_t                     geo;
    } pay2_t;

endpackage

`default_nettype wire

>>> rtl/rwc_div_cell.sv
`default_nettype none

module rwc_div_cell #(
    parameter int RW = 18,
    parameter int QW = 24,
    parameter int PW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [RW-1:0] in_rem,
    input  wire logic [RW-1:0] in_div,
    input  wire logic [QW-1:0] in_lo,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [RW-1:0]      out_rem,
    output logic [RW-1:0]      out_div,
    output logic [QW-1:0]      out_lo,
    output logic [PW-1:0]      out_pay
);

    logic          valid_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [RW-1:0] div_reg;
    logic [QW-1:0] lo_reg;
    logic [QW-1:0] lo_next;
    logic [PW-1:0] pay_reg;
    logic [RW:0]   trial;
    logic          ge;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial    = {in_rem, in_lo[QW-1]};
        ge       = (trial >= {1'b0, in_div});
        rem_next = ge ? RW'(trial - {1'b0, in_div}) : trial[RW-1:0];
        lo_next  = {in_lo[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= in_div;
        lo_reg  <= lo_next;
        pay_reg <= in_pay;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_lo    = lo_reg;
    assign out_pay   = pay_reg;

endmodule

`default_nettype wire

>>> rtl/rwc_div_chain.sv
`default_nettype none

module rwc_div_chain #(
    parameter int RW = 18,
    parameter int QW = 24,
    parameter int PW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [RW-1:0] in_rem,
    input  wire logic [RW-1:0] in_div,
    input  wire logic [QW-1:0] in_lo,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [RW-1:0]      out_rem,
    output logic [QW-1:0]      out_quo,
    output logic [PW-1:0]      out_pay
);

    logic          tap_valid [QW+1];
    logic [RW-1:0] tap_rem   [QW+1];
    logic [RW-1:0] tap_div   [QW+1];
    logic [QW-1:0] tap_lo    [QW+1];
    logic [PW-1:0] tap_pay   [QW+1];

    assign tap_valid[0] = in_valid;
    assign tap_rem[0]   = in_rem;
    assign tap_div[0]   = in_div;
    assign tap_lo[0]    = in_lo;
    assign tap_pay[0]   = in_pay;

    // One cell per quotient bit; after the last one the low word is the quotient.
    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        rwc_div_cell #(
            .RW (RW),
            .QW (QW),
            .PW (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (tap_valid[i]),
            .in_rem    (tap_rem[i]),
            .in_div    (tap_div[i]),
            .in_lo     (tap_lo[i]),
            .in_pay    (tap_pay[i]),
            .out_valid (tap_valid[i+1]),
            .out_rem   (tap_rem[i+1]),
            .out_div   (tap_div[i+1]),
            .out_lo    (tap_lo[i+1]),
            .out_pay   (tap_pay[i+1])
        );
    end

    assign out_valid = tap_valid[QW];
    assign out_rem   = tap_rem[QW] ^ tap_div[QW] ^ tap_div[QW];
    assign out_quo   = tap_lo[QW];
    assign out_pay   = tap_pay[QW];

endmodule

`default_nettype wire

>>> rtl/raycast_wall_column_setup.sv
// Wall column set-up for a raycaster. One ray hit word can be started in every
// clock cycle (busy is always low) and its result appears on the result ports,
// marked by done, for exactly one cycle; results leave in the order the words
// came in. Each word passes through two pipelined restoring dividers, one cell
// per quotient bit: 24 cells for the wall distance and 16 for the slice height,
// plus five register stages around them. The receiver must take every result in
// the cycle it is shown.
// Registers may only be written while no word is in flight.
`default_nettype none

module raycast_wall_column_setup
    import rwc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAP_SIZE  = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [POS_W-1:0]    pos_x,
    input  wire logic [POS_W-1:0]    pos_y,
    input  wire logic [RD_W-1:0]     ray_dir_x,
    input  wire logic [RD_W-1:0]     ray_dir_y,
    input  wire logic [CELL_W-1:0]   hit_cell_x,
    input  wire logic [CELL_W-1:0]   hit_cell_y,
    input  wire logic                hit_side,
    output logic                     done,
    output logic [WD_W-1:0]          wall_distance,
    output logic [SLICE_W-1:0]       slice_height,
    output logic [ROW_W-1:0]         first_row,
    output logic [ROW_W-1:0]         last_row,
    output logic [TEX_W-1:0]         texel_column,
    output logic [FL_W-1:0]          floor_x,
    output logic [FL_W-1:0]          floor_y,
    output logic                     math_fault
);

    localparam int CELL_MAX = (MAP_SIZE - 1 > 255) ? 255 : MAP_SIZE - 1;
    localparam int NA_W     = (CELL_W + 1 + FRAC_BITS > POS_W) ? CELL_W + 1 + FRAC_BITS : POS_W;
    localparam int NUM_W    = NA_W + 1;
    localparam int D1_W     = NA_W + FRAC_BITS;
    localparam int T1_W     = D1_W - WD_W;
    localparam int C1_W     = (T1_W > RD_W) ? T1_W : RD_W;
    localparam int D2_W     = HGT_W + FRAC_BITS;
    localparam int T2_W     = D2_W - SLICE_W;
    localparam int C2_W     = (T2_W > WD_W) ? T2_W : WD_W;
    localparam int SUM_W    = 2 * FRAC_BITS;
    localparam int TEXP_W   = FRAC_BITS + TW_W;
    localparam int FLC_W    = (CELL_W + 2 + FRAC_BITS > FL_W + 1) ?
                              CELL_W + 2 + FRAC_BITS : FL_W + 1;
    localparam int P1_W     = $bits(pay1_t);
    localparam int P2_W     = $bits(pay2_t);

    // ---------------------------------------------------------------- registers
    logic [HGT_W-1:0] screen_height_reg;
    logic [TW_W-1:0]  texture_width_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= SCREEN_HEIGHT_RST;
            texture_width_reg <= TEXTURE_WIDTH_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[HGT_W-1:0];
                REG_TEXTURE_WIDTH: texture_width_reg <= pwdata[TW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_SCREEN_HEIGHT: prdata = DATA_W'(screen_height_reg);
            REG_TEXTURE_WIDTH: prdata = DATA_W'(texture_width_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- stage A
    assign busy = 1'b0;

    logic [CELL_W-1:0]      cx_cl;
    logic [CELL_W-1:0]      cy_cl;
    logic [CELL_W-1:0]      cell_sel;
    logic [POS_W-1:0]       pos_sel;
    logic                   neg_sel;
    logic [CELL_W:0]        cell_p;
    logic signed [NUM_W-1:0] num_in;
    geo_t                   geo_in;

    always_comb
    begin
        cx_cl    = (hit_cell_x > CELL_W'(CELL_MAX)) ? CELL_W'(CELL_MAX) : hit_cell_x;
        cy_cl    = (hit_cell_y > CELL_W'(CELL_MAX)) ? CELL_W'(CELL_MAX) : hit_cell_y;
        cell_sel = hit_side ? cy_cl : cx_cl;
        pos_sel  = hit_side ? pos_y : pos_x;
        neg_sel  = hit_side ? ray_dir_y[RD_W-1] : ray_dir_x[RD_W-1];
        cell_p   = {1'b0, cell_sel} + {{CELL_W{1'b0}}, neg_sel};
        num_in   = NUM_W'({cell_p, {FRAC_BITS{1'b0}}}) - NUM_W'(pos_sel);
        geo_in.side      = hit_side;
        geo_in.rdx_neg   = ray_dir_x[RD_W-1];
        geo_in.rdy_neg   = ray_dir_y[RD_W-1];
        geo_in.cx        = cx_cl;
        geo_in.cy        = cy_cl;
        geo_in.other_pos = hit_side ? pos_x : pos_y;
        geo_in.other_rd  = hit_side ? $signed(ray_dir_x) : $signed(ray_dir_y);
    end

    logic                    a_valid_reg;
    logic signed [NUM_W-1:0] a_num_reg;
    logic [RD_W-1:0]         a_rd_reg;
    geo_t                    a_geo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_num_reg <= num_in;
        a_rd_reg  <= hit_side ? ray_dir_y : ray_dir_x;
        a_geo_reg <= geo_in;
    end

    // ---------------------------------------------------------------- stage B
    logic              b_valid_reg;
    logic [NA_W-1:0]   b_na_reg;
    logic [RD_W-1:0]   b_da_reg;
    dist_flags_t       b_flags_reg;
    geo_t              b_geo_reg;
    logic [NUM_W-1:0]  a_num_neg;
    logic [RD_W-1:0]   a_rd_neg;

    assign a_num_neg = NUM_W'(-a_num_reg);
    assign a_rd_neg  = RD_W'(-a_rd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_na_reg <= a_num_reg[NUM_W-1] ? a_num_neg[NA_W-1:0] : a_num_reg[NA_W-1:0];
        b_da_reg <= a_rd_reg[RD_W-1] ? a_rd_neg : a_rd_reg;
        b_flags_reg.rd_zero    <= (a_rd_reg == '0);
        b_flags_reg.num_zero   <= (a_num_reg == '0);
        b_flags_reg.wrong_sign <= (a_num_reg[NUM_W-1] != a_rd_reg[RD_W-1]);
        b_flags_reg.ovf        <= 1'b0;
        b_geo_reg <= a_geo_reg;
    end

    // ---------------------------------------------------------------- distance divider
    logic [D1_W-1:0] d1;
    logic [T1_W-1:0] top1;
    pay1_t           p1_in;
    pay1_t           p1_out;
    logic [P1_W-1:0] p1_out_vec;
    logic            c1_valid;
    logic [RD_W-1:0] c1_rem;
    logic [WD_W-1:0] c1_quo;

    always_comb
    begin
        d1           = {b_na_reg, {FRAC_BITS{1'b0}}};
        top1         = d1[D1_W-1:WD_W];
        p1_in        = {b_flags_reg, b_geo_reg};
        // A quotient that needs more than 24 bits shows up as a top part >= divisor.
        p1_in.flags.ovf = (C1_W'(top1) >= C1_W'(b_da_reg));
    end

    rwc_div_chain #(
        .RW (RD_W),
        .QW (WD_W),
        .PW (P1_W)
    ) u_div_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_rem    (RD_W'(top1)),
        .in_div    (b_da_reg),
        .in_lo     (d1[WD_W-1:0]),
        .in_pay    (p1_in),
        .out_valid (c1_valid),
        .out_rem   (c1_rem),
        .out_quo   (c1_quo),
        .out_pay   (p1_out_vec)
    );

    assign p1_out = p1_out_vec;

    // ---------------------------------------------------------------- stage C
    logic            c_valid_reg;
    logic [WD_W-1:0] c_dist_reg;
    logic            c_fault_reg;
    geo_t            c_geo_reg;
    logic [WD_W-1:0] dist_sel;
    logic            fault1;

    always_comb
    begin
        if (p1_out.flags.rd_zero)
        begin
            dist_sel = '1;
        end
        else if (p1_out.flags.num_zero || p1_out.flags.wrong_sign)
        begin
            dist_sel = '0;
        end
        else if (p1_out.flags.ovf)
        begin
            dist_sel = '1;
        end
        else
        begin
            dist_sel = c1_quo;
        end
        fault1 = p1_out.flags.rd_zero
               | (!p1_out.flags.num_zero & (p1_out.flags.wrong_sign | p1_out.flags.ovf))
               | (c1_rem != c1_rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        c_dist_reg  <= dist_sel;
        c_fault_reg <= fault1;
        c_geo_reg   <= p1_out.geo;
    end

    // ---------------------------------------------------------------- slice divider
    logic [D2_W-1:0]          d2;
    logic [T2_W-1:0]          top2;
    pay2_t                    p2_in;
    pay2_t                    p2_out;
    logic [P2_W-1:0]          p2_out_vec;
    logic                     c2_valid;
    logic [WD_W-1:0]          c2_rem;
    logic [SLICE_W-1:0]       c2_quo;

    always_comb
    begin
        d2               = {screen_height_reg, {FRAC_BITS{1'b0}}};
        top2             = d2[D2_W-1:SLICE_W];
        p2_in.wall_dist  = c_dist_reg;
        p2_in.fault      = c_fault_reg;
        // Zero distance also lands here, as top part >= 0 always holds.
        p2_in.ovf        = (C2_W'(top2) >= C2_W'(c_dist_reg));
        p2_in.prod       = $signed({1'b0, c_dist_reg}) * $signed(c_geo_reg.other_rd);
        p2_in.geo        = c_geo_reg;
    end

    rwc_div_chain #(
        .RW (WD_W),
        .QW (SLICE_W),
        .PW (P2_W)
    ) u_div_slice (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_rem    (WD_W'(top2)),
        .in_div    (c_dist_reg),
        .in_lo     (d2[SLICE_W-1:0]),
        .in_pay    (p2_in),
        .out_valid (c2_valid),
        .out_rem   (c2_rem),
        .out_quo   (c2_quo),
        .out_pay   (p2_out_vec)
    );

    assign p2_out = p2_out_vec;

    // ---------------------------------------------------------------- stage D
    logic                 d_valid_reg;
    logic [WD_W-1:0]      d_dist_reg;
    logic [SLICE_W-1:0]   d_slice_reg;
    logic                 d_fault_reg;
    logic [FRAC_BITS-1:0] d_frac_reg;
    geo_t                 d_geo_reg;
    logic [SUM_W-1:0]     hit_sum;

    assign hit_sum = SUM_W'({p2_out.geo.other_pos, {FRAC_BITS{1'b0}}}) + SUM_W'(p2_out.prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_dist_reg  <= p2_out.wall_dist;
        d_slice_reg <= p2_out.ovf ? '1 : c2_quo;
        d_fault_reg <= p2_out.fault | p2_out.ovf | (c2_rem != c2_rem);
        d_frac_reg  <= hit_sum[SUM_W-1:FRAC_BITS];
        d_geo_reg   <= p2_out.geo;
    end

    // ---------------------------------------------------------------- stage E
    logic [TEXP_W-1:0]  tex_prod;
    logic [TW_W-1:0]    tex_int;
    logic               tex_sat;
    logic [TEX_W-1:0]   tex_val;
    logic [HGT_W-2:0]   half_h;
    logic [SLICE_W-2:0] half_s;
    logic [ROW_W-1:0]   first_val;
    logic [SLICE_W-1:0] last_sum;
    logic [ROW_W-1:0]   last_val;
    logic [FLC_W-1:0]   fx_full;
    logic [FLC_W-1:0]   fy_full;
    logic [FLC_W-1:0]   one_full;
    logic               fx_sat;
    logic               fy_sat;

    always_comb
    begin
        tex_prod = TEXP_W'(d_frac_reg) * TEXP_W'(texture_width_reg);
        tex_int  = tex_prod[TEXP_W-1:FRAC_BITS];
        tex_sat  = tex_int[TW_W-1];
        tex_val  = tex_sat ? '1 : tex_int[TEX_W-1:0];

        half_h = screen_height_reg[HGT_W-1:1];
        half_s = d_slice_reg[SLICE_W-1:1];
        if (SLICE_W'(half_s) > SLICE_W'(half_h))
        begin
            first_val = '0;
        end
        else
        begin
            first_val = ROW_W'(SLICE_W'(half_h) - SLICE_W'(half_s));
        end
        last_sum = SLICE_W'(half_s) + SLICE_W'(half_h);
        if (last_sum >= SLICE_W'(screen_height_reg))
        begin
            last_val = (screen_height_reg == '0) ? '0 : screen_height_reg - 1'b1;
        end
        else
        begin
            last_val = last_sum[ROW_W-1:0];
        end

        one_full = FLC_W'({1'b1, {FRAC_BITS{1'b0}}});
        fx_full  = FLC_W'({d_geo_reg.cx, {FRAC_BITS{1'b0}}})
                 + (d_geo_reg.side ? FLC_W'(d_frac_reg) : '0)
                 + ((!d_geo_reg.side && d_geo_reg.rdx_neg) ? one_full : '0);
        fy_full  = FLC_W'({d_geo_reg.cy, {FRAC_BITS{1'b0}}})
                 + (d_geo_reg.side ? '0 : FLC_W'(d_frac_reg))
                 + ((d_geo_reg.side && d_geo_reg.rdy_neg) ? one_full : '0);
        fx_sat   = (fx_full > FLC_W'({FL_W{1'b1}}));
        fy_sat   = (fy_full > FLC_W'({FL_W{1'b1}}));
    end

    logic               done_reg;
    logic [WD_W-1:0]    wall_distance_reg;
    logic [SLICE_W-1:0] slice_height_reg;
    logic [ROW_W-1:0]   first_row_reg;
    logic [ROW_W-1:0]   last_row_reg;
    logic [TEX_W-1:0]   texel_column_reg;
    logic [FL_W-1:0]    floor_x_reg;
    logic [FL_W-1:0]    floor_y_reg;
    logic               math_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wall_distance_reg <= d_dist_reg;
        slice_height_reg  <= d_slice_reg;
        first_row_reg     <= first_val;
        last_row_reg      <= last_val;
        texel_column_reg  <= tex_val;
        floor_x_reg       <= fx_sat ? '1 : fx_full[FL_W-1:0];
        floor_y_reg       <= fy_sat ? '1 : fy_full[FL_W-1:0];
        math_fault_reg    <= d_fault_reg | tex_sat | fx_sat | fy_sat;
    end

    assign done          = done_reg;
    assign wall_distance = wall_distance_reg;
    assign slice_height  = slice_height_reg;
    assign first_row     = first_row_reg;
    assign last_row      = last_row_reg;
    assign texel_column  = texel_column_reg;
    assign floor_x       = floor_x_reg;
    assign floor_y       = floor_y_reg;
    assign math_fault    = math_fault_reg;

endmodule

`default_nettype wire
